// ----- sv/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the 5x5 box mean filter: payload structs,
// configuration register codes and frame size limits.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int PixW       = 8;
	localparam int CfgW       = 11;
	localparam int CfgIdxW    = 1;
	localparam int MinDim     = 5;
	localparam int MaxHeight  = 1024;
	localparam int ResetDim   = 512;
	localparam int MaxWidth   = 1024;
	localparam int WindowSize = 5;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic            drain;
	} pix_item_t;

	typedef struct packed {
		logic [PixW-1:0] mean_pixel;
		logic            frame_end;
	} mean_item_t;

endpackage

// ----- sv/bmf_ram.sv -----
// ----------------------------------------------------------------------------
// bmf_ram
// Generic simple dual port RAM: one write port, one read port with the read
// data registered and held while no read is issued.
// ----------------------------------------------------------------------------
module bmf_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/box_mean_filter_5x5.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter_5x5
// Streaming box mean over a square window with zero padding at the frame edge.
// ----------------------------------------------------------------------------
// Pixels enter on the pix channel in raster order (pix_valid / pix_stall /
// pix_item); means leave on the mean channel (mean_valid / mean_stall /
// mean_item). One item is taken per cycle. Each item yields at most one mean,
// which lags the input by two rows and two columns; after the last pixel,
// items with drain set push padding zeros until the mean marked frame_end
// has gone out, after which the next item is pixel (0,0) of a new frame.
// A mean reaches the output register after its item passes the memory stage,
// where the line memory read data and the row sums are formed, then the total
// and the reciprocal multiply take one stage each. The line memory
// read-modify-write sets the one item per cycle rate; columns repeat only
// every frame_width items. When mean_stall is high the result holds and the
// stages behind it fill up; pix_stall rises only once the memory stage itself
// cannot move. Reset sets the height to 512, the width to min(512, MAX_WIDTH)
// and the position to (0,0). The line memory is not cleared: rows before the
// frame start are masked as padding. A configuration write restarts the
// frame; the user makes it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module box_mean_filter_5x5 #(
	parameter int MAX_WIDTH   = bmf_pkg::MaxWidth,
	parameter int WINDOW_SIZE = bmf_pkg::WindowSize
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  bmf_pkg::pix_item_t           pix_item,
	output logic                         mean_valid,
	input  logic                         mean_stall,
	output bmf_pkg::mean_item_t          mean_item,
	input  logic                         cfg_we,
	input  logic [bmf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bmf_pkg::CfgW-1:0]     cfg_wdata
);

	localparam int PixW     = bmf_pkg::PixW;
	localparam int CfgW     = bmf_pkg::CfgW;
	localparam int RowW     = bmf_pkg::CfgW;
	localparam int Ws       = WINDOW_SIZE;
	localparam int Half     = WINDOW_SIZE / 2;
	localparam int Lines    = WINDOW_SIZE - 1;
	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int CW       = WW + 2;
	localparam int CmpW     = (WW > CfgW) ? WW : CfgW;
	localparam int PixMax   = (1 << PixW) - 1;
	localparam int Area     = WINDOW_SIZE * WINDOW_SIZE;
	localparam int RsW      = $clog2(WINDOW_SIZE * PixMax + 1);
	localparam int SumW     = $clog2(Area * PixMax + 1);
	localparam int DivShift = SumW + $clog2(Area);
	localparam int RecipK   = ((1 << DivShift) + Area - 1) / Area;
	localparam int KW       = $clog2(RecipK + 1);
	localparam int ProdW    = (SumW + KW > DivShift + PixW) ? (SumW + KW) : (DivShift + PixW);
	localparam int WReset   = (MAX_WIDTH < bmf_pkg::ResetDim) ? MAX_WIDTH : bmf_pkg::ResetDim;

	// configuration and position
	logic [WW-1:0]   w_q;
	logic [CfgW-1:0] h_q;
	logic [AW-1:0]   col_q;
	logic [RowW-1:0] row_q;
	logic [WW-1:0]   w_clamp;
	logic [CfgW-1:0] h_clamp;
	logic            cfg_hit;

	// entry stage
	logic            pix_acc;
	logic            c_lo;
	logic            out_ok;
	logic            fend;
	logic            last_col;
	logic [Ws-1:0]   rmask;
	logic [Ws-1:0]   cmask;
	logic [PixW-1:0] px_in;

	// memory stage
	logic            vld_s1;
	logic            out_s1;
	logic            fend_s1;
	logic [PixW-1:0] px_s1;
	logic [Ws-1:0]   rmask_s1;
	logic [Ws-1:0]   cmask_s1;
	logic [AW-1:0]   addr_s1;
	logic            adv1;

	logic [Lines*PixW-1:0] ram_rdata;
	logic [Lines*PixW-1:0] ram_wdata;
	logic [PixW-1:0]       col_new   [Ws];
	logic [PixW-1:0]       win_q     [Ws][Ws];
	logic [PixW-1:0]       win_next  [Ws][Ws];
	logic [RsW-1:0]        rsum_next [Ws];

	// sum and divide stages
	logic             vld_s2, vld_s3, vld_s4;
	logic             fend_s2, fend_s3, fend_s4;
	logic [RsW-1:0]   rsum_s2 [Ws];
	logic [SumW-1:0]  sum_next;
	logic [SumW-1:0]  sum_s3;
	logic [ProdW-1:0] prod_s4;
	logic             adv2, adv3, adv4;
	logic             free2, free3, free4;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_comb begin
		cfg_hit = (cfg_index == bmf_pkg::REG_FRAME_WIDTH) ||
			(cfg_index == bmf_pkg::REG_FRAME_HEIGHT);
		if (cfg_wdata < CfgW'(bmf_pkg::MinDim)) begin
			w_clamp = WW'(bmf_pkg::MinDim);
		end else if (CmpW'(cfg_wdata) > CmpW'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg_wdata);
		end
		if (cfg_wdata < CfgW'(bmf_pkg::MinDim)) begin
			h_clamp = CfgW'(bmf_pkg::MinDim);
		end else if (cfg_wdata > CfgW'(bmf_pkg::MaxHeight)) begin
			h_clamp = CfgW'(bmf_pkg::MaxHeight);
		end else begin
			h_clamp = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(WReset);
			h_q <= CfgW'(bmf_pkg::ResetDim);
		end else if (cfg_we) begin
			case (cfg_index)
				bmf_pkg::REG_FRAME_WIDTH:  w_q <= w_clamp;
				bmf_pkg::REG_FRAME_HEIGHT: h_q <= h_clamp;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// entry stage: position decode, padding masks, counters
	// ------------------------------------------------------------------
	assign pix_acc = pix_valid && !pix_stall;

	always_comb begin
		logic signed [RowW+1:0] rbase;
		logic signed [RowW+1:0] ri;
		logic [CW-1:0]          cj;
		px_in    = pix_item.drain ? '0 : pix_item.pixel;
		c_lo     = ({1'b0, col_q} < (AW+1)'(Half));
		out_ok   = c_lo ? (row_q >= RowW'(Half + 1)) : (row_q >= RowW'(Half));
		fend     = (col_q == AW'(Half - 1)) &&
			({1'b0, row_q} >= ({1'b0, h_q} + (RowW+1)'(Half)));
		last_col = (WW'(col_q) == (w_q - WW'(1)));
		rbase    = $signed({2'b00, row_q}) - $signed((RowW+2)'(Lines)) -
			$signed({{(RowW+1){1'b0}}, c_lo});
		for (int i = 0; i < Ws; i++) begin
			ri       = rbase + $signed((RowW+2)'(i));
			rmask[i] = !ri[RowW+1] && (ri < $signed({2'b00, h_q}));
		end
		for (int j = 0; j < Ws; j++) begin
			cj = CW'(col_q) + CW'(j);
			if (c_lo) begin
				cmask[j] = (cj < CW'(Lines)) && ((cj + CW'(w_q)) >= CW'(Lines));
			end else begin
				cmask[j] = (cj >= CW'(Lines));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we && cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (out_ok && fend) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				if (row_q != '1) begin
					row_q <= row_q + RowW'(1);
				end
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// memory stage: column read-modify-write and window shift
	// ------------------------------------------------------------------
	assign free2     = !vld_s2 || adv2;
	assign adv1      = vld_s1 && (!out_s1 || free2);
	assign pix_stall = vld_s1 && !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			out_s1   <= out_ok;
			fend_s1  <= fend;
			px_s1    <= px_in;
			rmask_s1 <= rmask;
			cmask_s1 <= cmask;
			addr_s1  <= col_q;
		end
	end

	bmf_ram #(
		.DATA_W (Lines * PixW),
		.DEPTH  (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (adv1),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (pix_acc),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic [RsW-1:0] acc;
		for (int i = 0; i < Lines; i++) begin
			col_new[i] = ram_rdata[i*PixW +: PixW];
		end
		col_new[Ws-1] = px_s1;
		for (int i = 0; i < Lines - 1; i++) begin
			ram_wdata[i*PixW +: PixW] = ram_rdata[(i+1)*PixW +: PixW];
		end
		ram_wdata[(Lines-1)*PixW +: PixW] = px_s1;
		for (int i = 0; i < Ws; i++) begin
			for (int j = 0; j < Ws - 1; j++) begin
				win_next[i][j] = win_q[i][j+1];
			end
			win_next[i][Ws-1] = col_new[i];
		end
		for (int i = 0; i < Ws; i++) begin
			acc = '0;
			for (int j = 0; j < Ws; j++) begin
				if (rmask_s1[i] && cmask_s1[j]) begin
					acc = acc + RsW'(win_next[i][j]);
				end
			end
			rsum_next[i] = acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			win_q <= win_next;
		end
		if (adv1 && out_s1) begin
			rsum_s2 <= rsum_next;
			fend_s2 <= fend_s1;
		end
	end

	// ------------------------------------------------------------------
	// total, reciprocal multiply, output register
	// ------------------------------------------------------------------
	assign free4 = !vld_s4 || !mean_stall;
	assign adv4  = vld_s4 && !mean_stall;
	assign free3 = !vld_s3 || free4;
	assign adv3  = vld_s3 && free4;
	assign adv2  = vld_s2 && free3;

	always_comb begin
		sum_next = '0;
		for (int i = 0; i < Ws; i++) begin
			sum_next = sum_next + SumW'(rsum_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1 && out_s1) begin
				vld_s2 <= 1'b1;
			end else if (adv2) begin
				vld_s2 <= 1'b0;
			end
			if (adv2) begin
				vld_s3 <= 1'b1;
			end else if (adv3) begin
				vld_s3 <= 1'b0;
			end
			if (adv3) begin
				vld_s4 <= 1'b1;
			end else if (adv4) begin
				vld_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s3  <= sum_next;
			fend_s3 <= fend_s2;
		end
		if (adv3) begin
			prod_s4 <= ProdW'(sum_s3) * ProdW'(RecipK);
			fend_s4 <= fend_s3;
		end
	end

	assign mean_valid           = vld_s4;
	assign mean_item.mean_pixel = prod_s4[DivShift +: PixW];
	assign mean_item.frame_end  = fend_s4;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < w_q)
		else $error("column counter beyond frame width");

	a_dims_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(w_q >= WW'(bmf_pkg::MinDim)) && (h_q >= CfgW'(bmf_pkg::MinDim)) &&
		(h_q <= CfgW'(bmf_pkg::MaxHeight)))
		else $error("frame dimensions outside clamp range");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && out_ok && fend |=> (col_q == '0) && (row_q == '0))
		else $error("position not restarted after frame end item");

	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && adv1 |-> col_q != addr_s1)
		else $error("line memory read and write hit the same column");

	a_mean_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(vld_s1 && out_s1))
		else $error("sum stage filled without a producing item");

endmodule
